// ===== design/gf128_pkg.sv =====
// Package for the GF(2^128) multiplier: widths and carry-less helper functions.
`default_nettype none
package gf128_pkg;

  localparam int unsigned HalfW = 64;
  localparam int unsigned OperW = 2 * HalfW;
  localparam int unsigned PartW = OperW + HalfW;
  localparam int unsigned ProdW = 2 * OperW;
  // Number of bits that the first fold pushes past x^127
  localparam int unsigned SpillW = 7;

  typedef logic [HalfW-1:0] half_t;
  typedef logic [OperW-1:0] oper_t;
  typedef logic [PartW-1:0] part_t;
  typedef logic [ProdW-1:0] prod_t;
  typedef logic [SpillW-1:0] spill_t;

  // Carry-less product of a 128-bit and a 64-bit polynomial
  function automatic part_t clmul_128x64(input oper_t a, input half_t b);
    part_t         res;
    logic [HalfW-1:0] term;
    int            idx;
    res = '0;
    for (int k = 0; k < PartW; k++) begin
      term = '0;
      // Gather every coefficient pair that lands on x^k
      for (int j = 0; j < HalfW; j++) begin
        idx = k - j;
        if (idx >= 0 && idx < OperW) begin
          term[j] = a[idx] & b[j];
        end
      end
      res[k] = ^term;
    end
    return res;
  endfunction

  // Reduce a 256-bit product modulo x^128 + x^7 + x^2 + x + 1
  function automatic oper_t reduce_256(input prod_t p);
    oper_t  lo;
    oper_t  hi;
    oper_t  fold;
    spill_t s;
    logic [2*SpillW-1:0] s_ext;
    lo   = p[OperW-1:0];
    hi   = p[ProdW-1:OperW];
    // First fold: hi * (x^7 + x^2 + x + 1), upper bits dropped
    fold = lo ^ hi ^ (hi << 1) ^ (hi << 2) ^ (hi << 7);
    // Second fold: the spilled bits times the same polynomial
    s = {{(SpillW-1){1'b0}}, hi[OperW-1]}
      ^ {{(SpillW-2){1'b0}}, hi[OperW-1:OperW-2]}
      ^ hi[OperW-1:OperW-SpillW];
    s_ext = {{SpillW{1'b0}}, s};
    s_ext = s_ext ^ (s_ext << 1) ^ (s_ext << 2) ^ (s_ext << 7);
    fold = fold ^ {{(OperW-2*SpillW){1'b0}}, s_ext};
    return fold;
  endfunction

endpackage
`default_nettype wire

// ===== design/gf128_multiply.sv =====
// Top level: pipelined GF(2^128) multiplier on stream channels.
//
// One operand pair comes in per transfer on the s_axis side; the reduced
// field product leaves on the m_axis side, one result per operand pair,
// in order. Bit i of each element is the coefficient of x^i, and the
// product is reduced modulo x^128 + x^7 + x^2 + x + 1.
//
// Three register stages: the product with the low half of b, the product
// with the high half of b merged in, then the two-fold reduction. The
// result leaves from the register of the third stage. One transfer is
// taken every cycle while the output side keeps up.
//
// Each stage holds its own valid bit. A stage advances when it is empty
// or the stage after it advances, so a stall on m_axis_tready backs up
// stage by stage without losing or repeating an item, and s_axis_tready
// drops only once all three stages are full.
//
// Reset clears the valid bits; the payload registers are not reset.
`default_nettype none
module gf128_multiply (
  input  wire  logic                         clk_i,
  input  wire  logic                         rst_ni,
  input  wire  logic                         s_axis_tvalid,
  output logic                               s_axis_tready,
  // a_lo [63:0], a_hi [127:64], b_lo [191:128], b_hi [255:192]
  input  wire  logic [2*gf128_pkg::OperW-1:0] s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire  logic                         m_axis_tready,
  // prod_lo [63:0], prod_hi [127:64]
  output logic [gf128_pkg::OperW-1:0]        m_axis_tdata
);
  import gf128_pkg::*;

  oper_t in_a;
  half_t in_b_lo;
  half_t in_b_hi;

  logic  s1_v_q, s1_v_d, s1_rdy;
  oper_t s1_a_q;
  half_t s1_b_hi_q;
  part_t s1_part_q, s1_part_d;

  logic  s2_v_q, s2_v_d, s2_rdy;
  prod_t s2_prod_q, s2_prod_d;

  logic  s3_v_q, s3_v_d, s3_rdy;
  oper_t s3_res_q, s3_res_d;

  // Unpack the operand pair
  assign in_a    = s_axis_tdata[OperW-1:0];
  assign in_b_lo = s_axis_tdata[OperW+HalfW-1:OperW];
  assign in_b_hi = s_axis_tdata[2*OperW-1:OperW+HalfW];

  // Advance a stage when it is empty or its successor advances
  assign s3_rdy = !s3_v_q || m_axis_tready;
  assign s2_rdy = !s2_v_q || s3_rdy;
  assign s1_rdy = !s1_v_q || s2_rdy;

  assign s_axis_tready = s1_rdy;

  // Stage datapaths
  assign s1_part_d = clmul_128x64(in_a, in_b_lo);
  assign s2_prod_d = {clmul_128x64(s1_a_q, s1_b_hi_q), {HalfW{1'b0}}}
                   ^ {{HalfW{1'b0}}, s1_part_q};
  assign s3_res_d  = reduce_256(s2_prod_q);

  // Move valid bits with the data
  assign s1_v_d = s1_rdy ? s_axis_tvalid : s1_v_q;
  assign s2_v_d = s2_rdy ? s1_v_q : s2_v_q;
  assign s3_v_d = s3_rdy ? s2_v_q : s3_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
      s3_v_q <= s3_v_d;
    end
  end

  // Hold payload while a stage is stalled
  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_a_q    <= in_a;
      s1_b_hi_q <= in_b_hi;
      s1_part_q <= s1_part_d;
    end
    if (s2_rdy) begin
      s2_prod_q <= s2_prod_d;
    end
    if (s3_rdy) begin
      s3_res_q <= s3_res_d;
    end
  end

  assign m_axis_tvalid = s3_v_q;
  assign m_axis_tdata  = s3_res_q;

endmodule
`default_nettype wire
